// ===== src/mam_pkg.sv =====
// Package for the small matrix engine: op codes, result mode codes and the
// per-step tag that travels from the sequencer into the datapath.
// No dependencies.
package mam_pkg;

  localparam int VAL_W = 35;

  localparam logic [2:0] OP_WR_A  = 3'd0;
  localparam logic [2:0] OP_WR_B  = 3'd1;
  localparam logic [2:0] OP_SUM   = 3'd2;
  localparam logic [2:0] OP_PROD  = 3'd3;
  localparam logic [2:0] OP_TRANS = 3'd4;

  typedef enum logic [1:0] {
    MODE_SUM   = 2'd0,
    MODE_PROD  = 2'd1,
    MODE_TRANS = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       first;
    logic       emit;
    logic       last;
    logic       err;
    mode_t      mode;
  } tag_t;

endpackage

// ===== src/mam_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing.
interface mam_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [2:0]        row_index;
  logic [2:0]        col_index;
  logic signed [15:0] elem_value;
  modport source (output valid, output op, output row_index, output col_index,
                  output elem_value, input ready);
  modport sink (input valid, input op, input row_index, input col_index,
                input elem_value, output ready);
endinterface

interface mam_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        out_row;
  logic [2:0]        out_col;
  logic signed [34:0] out_value;
  logic              status;
  logic              is_last;
  modport source (output valid, output out_row, output out_col, output out_value,
                  output status, output is_last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input status, input is_last, output ready);
endinterface

// ===== src/mam_ram.sv =====
// Simple dual-port element store with one write port and one registered read port.
// Depends on nothing.
module mam_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [WIDTH-1:0] rdata
);
  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== src/mam_seq.sv =====
// Command sequencer: configuration registers, element writes and the row, column
// and inner-index walk that issues store reads. Depends on mam_pkg and mam_if.
module mam_seq #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int IW         = 3,
  parameter int AW         = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mam_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [3:0]                    cfg_wdata,
  input  logic                          advance,
  output logic                          we_a,
  output logic                          we_b,
  output logic [AW-1:0]                 waddr,
  output logic signed [ELEM_WIDTH-1:0]  wdata,
  output logic [AW-1:0]                 raddr_a,
  output logic [AW-1:0]                 raddr_b,
  output logic                          issue_valid,
  output mam_pkg::tag_t                 issue_tag
);
  import mam_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  function automatic logic [IW-1:0] dim_m1(input logic [3:0] r);
    logic [IW-1:0] res;
    if (r == 4'd0) begin
      res = '0;
    end else if (int'(r) > MAX_DIM) begin
      res = IW'(MAX_DIM - 1);
    end else begin
      res = IW'(r - 4'd1);
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

  logic [3:0]    a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic          err_r, err_nxt;
  logic [IW-1:0] lim_i_r, lim_i_nxt, lim_j_r, lim_j_nxt, lim_k_r, lim_k_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IW-1:0] ar, ac, br, bc;
  logic          accept, in_range, k_end, j_end, i_end;
  logic [IW-1:0] a_row, a_col, b_row, b_col;

  assign ar = dim_m1(a_rows_r);
  assign ac = dim_m1(a_cols_r);
  assign br = dim_m1(b_rows_r);
  assign bc = dim_m1(b_cols_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.row_index) < MAX_DIM) && (int'(in_ch.col_index) < MAX_DIM);

  assign we_a  = accept && (in_ch.op == OP_WR_A) && in_range;
  assign we_b  = accept && (in_ch.op == OP_WR_B) && in_range;
  assign waddr = addr_of(IW'(in_ch.row_index), IW'(in_ch.col_index));
  assign wdata = ELEM_WIDTH'(in_ch.elem_value);

  assign k_end = (k_r == lim_k_r);
  assign j_end = (j_r == lim_j_r);
  assign i_end = (i_r == lim_i_r);

  always_comb begin
    a_row = i_r;
    a_col = k_r;
    b_row = k_r;
    b_col = j_r;
    case (mode_r)
      MODE_SUM: begin
        a_col = j_r;
        b_row = i_r;
      end
      MODE_TRANS: begin
        a_row = j_r;
        a_col = i_r;
      end
      default: begin
      end
    endcase
  end

  assign raddr_a = addr_of(a_row, a_col);
  assign raddr_b = addr_of(b_row, b_col);

  assign issue_valid     = (state_r == ST_RUN);
  assign issue_tag.row   = 3'(i_r);
  assign issue_tag.col   = 3'(j_r);
  assign issue_tag.first = (k_r == '0);
  assign issue_tag.emit  = k_end;
  assign issue_tag.last  = k_end && j_end && i_end;
  assign issue_tag.err   = err_r;
  assign issue_tag.mode  = mode_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    err_nxt   = err_r;
    lim_i_nxt = lim_i_r;
    lim_j_nxt = lim_j_r;
    lim_k_nxt = lim_k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        err_nxt = 1'b0;
        lim_k_nxt = '0;
        if (accept) begin
          case (in_ch.op)
            OP_SUM: begin
              state_nxt = ST_RUN;
              mode_nxt  = MODE_SUM;
              lim_i_nxt = ar;
              lim_j_nxt = ac;
              err_nxt   = (ar != br) || (ac != bc);
            end
            OP_PROD: begin
              state_nxt = ST_RUN;
              mode_nxt  = MODE_PROD;
              lim_i_nxt = ar;
              lim_j_nxt = bc;
              lim_k_nxt = ac;
              err_nxt   = (ac != br);
            end
            OP_TRANS: begin
              state_nxt = ST_RUN;
              mode_nxt  = MODE_TRANS;
              lim_i_nxt = ac;
              lim_j_nxt = ar;
            end
            default: begin
            end
          endcase
          if (err_nxt) begin
            lim_i_nxt = '0;
            lim_j_nxt = '0;
            lim_k_nxt = '0;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          k_nxt = k_end ? '0 : k_r + 1'b1;
          if (k_end) begin
            j_nxt = j_end ? '0 : j_r + 1'b1;
            if (j_end) begin
              i_nxt = i_r + 1'b1;
              if (i_end) begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      a_rows_r <= 4'd8;
      a_cols_r <= 4'd8;
      b_rows_r <= 4'd8;
      b_cols_r <= 4'd8;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_A_ROWS: a_rows_r <= cfg_wdata;
          REG_A_COLS: a_cols_r <= cfg_wdata;
          REG_B_ROWS: b_rows_r <= cfg_wdata;
          REG_B_COLS: b_cols_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    err_r   <= err_nxt;
    lim_i_r <= lim_i_nxt;
    lim_j_r <= lim_j_nxt;
    lim_k_r <= lim_k_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
  end
endmodule

// ===== src/mam_alu.sv =====
// Datapath: combines the two store read words, accumulates inner products and
// holds the result beat. Depends on mam_pkg and mam_if.
module mam_alu #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue_valid,
  input  mam_pkg::tag_t                 issue_tag,
  input  logic signed [ELEM_WIDTH-1:0]  a_rd,
  input  logic signed [ELEM_WIDTH-1:0]  b_rd,
  output logic                          advance,
  mam_out_if.source                     out_ch
);
  import mam_pkg::*;

  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic                        s1_r, s2_r, out_valid_r;
  tag_t                        tag1_r, tag2_r;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ELEM_WIDTH:0]  sum;
  logic signed [VAL_W-1:0]     term, term_r, acc_r, acc_nxt;
  logic signed [VAL_W-1:0]     val_r;
  logic [2:0]                  row_r, col_r;
  logic                        status_r, last_r;

  assign advance = !out_valid_r || out_ch.ready;

  assign prod = a_rd * b_rd;
  assign sum  = (ELEM_WIDTH + 1)'(a_rd) + (ELEM_WIDTH + 1)'(b_rd);

  always_comb begin
    case (tag1_r.mode)
      MODE_SUM:   term = VAL_W'(sum);
      MODE_PROD:  term = VAL_W'(prod);
      MODE_TRANS: term = VAL_W'(a_rd);
      default:    term = '0;
    endcase
    if (tag1_r.err) begin
      term = '0;
    end
  end

  assign acc_nxt = (tag2_r.first ? VAL_W'(0) : acc_r) + term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_r        <= issue_valid;
      s2_r        <= s1_r;
      out_valid_r <= s2_r && tag2_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag1_r <= issue_tag;
      tag2_r <= tag1_r;
      term_r <= term;
      if (s2_r) begin
        acc_r <= acc_nxt;
        if (tag2_r.emit) begin
          val_r    <= acc_nxt;
          row_r    <= tag2_r.row;
          col_r    <= tag2_r.col;
          status_r <= tag2_r.err;
          last_r   <= tag2_r.last;
        end
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = row_r;
  assign out_ch.out_col   = col_r;
  assign out_ch.out_value = val_r;
  assign out_ch.status    = status_r;
  assign out_ch.is_last   = last_r;
endmodule

// ===== src/matrix_add_multiply_transpose_top.sv =====
// Top level of the small matrix engine: two element stores, the sequencer and
// the datapath. Depends on mam_pkg, mam_if, mam_ram, mam_seq and mam_alu.
//
// Usage: in_ch carries command beats. Ops write A, write B, sum, product and
// transpose of A. Writes produce no result beat. A command streams its
// result elements on out_ch in row-major order with is_last set on the
// final beat; a dimension mismatch gives a single beat with status set.
// Dimensions come from four registers on the cfg_ port; the user must write
// them only while the engine is idle, which the block itself does not enforce.
// Throughput: sum and transpose give one beat per cycle while out_ch is not
// stalled; a product element takes one multiply-accumulate step per column
// of A, and each step is one read from each store. A command's first beat
// passes through the store read, combine and accumulate registers. in_ch
// stays low on ready while a command is being walked; the next beat is
// taken the cycle after the last read is issued.
// Reset sets all dimension registers to 8 and empties the pipeline; store
// contents are undefined until written. When out_ch is stalled the whole
// read and accumulate pipeline holds in place.
module matrix_add_multiply_transpose_top #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mam_in_if.sink     in_ch,
  mam_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_wdata
);
  import mam_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(DEPTH);

  logic                          advance, we_a, we_b, issue_valid;
  logic [AW-1:0]                 waddr, raddr_a, raddr_b;
  logic signed [ELEM_WIDTH-1:0]  wdata, a_rd, b_rd;
  tag_t                          issue_tag;

  mam_seq #(
    .MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH), .IW(IW), .AW(AW)
  ) u_seq (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .advance(advance), .we_a(we_a), .we_b(we_b), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b),
    .issue_valid(issue_valid), .issue_tag(issue_tag)
  );

  mam_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .AW(AW)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata),
    .re(advance), .raddr(raddr_a), .rdata(a_rd)
  );

  mam_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .AW(AW)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata),
    .re(advance), .raddr(raddr_b), .rdata(b_rd)
  );

  mam_alu #(.ELEM_WIDTH(ELEM_WIDTH)) u_alu (
    .clk(clk), .rst_n(rst_n), .issue_valid(issue_valid), .issue_tag(issue_tag),
    .a_rd(a_rd), .b_rd(b_rd), .advance(advance), .out_ch(out_ch)
  );
endmodule

// ===== tb/matrix_add_multiply_transpose_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the small matrix engine: element writes, sum, product and
// transpose commands under random handshake idling and several dimension settings.
// Depends on mam_pkg, mam_if and matrix_add_multiply_transpose_top.
module matrix_add_multiply_transpose_top_test;
  import mam_pkg::*;

  localparam int DIM_MAX = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 15;
  localparam int RANDOM_ITEMS = 22;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  localparam logic [2:0] OP_RSVD_FIRST = OP_TRANS + 3'd1;

  typedef struct {
    logic [2:0]        op;
    logic [2:0]        row;
    logic [2:0]        col;
    logic signed [15:0] value;
  } cmd_item_t;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [34:0] value;
    logic               status;
    logic               last;
  } elem_beat_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_wdata;

  mam_in_if  in_ch ();
  mam_out_if out_ch ();

  matrix_add_multiply_transpose_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cmd_item_t          pending_cmds[$];
  elem_beat_t         expected_beats[$];
  logic signed [15:0] a_elems [DIM_MAX][DIM_MAX];
  logic signed [15:0] b_elems [DIM_MAX][DIM_MAX];
  logic [3:0]         dim_regs [4];
  cmd_item_t          next_cmd;
  cmd_item_t          taken_cmd;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 error_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns ERROR: %s", $time, msg);
    error_count++;
  endtask

  function automatic int eff_dim(logic [3:0] raw);
    if (raw == 4'd0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return raw;
  endfunction

  function automatic void push_beat(int r, int c, longint v, logic st, logic last);
    elem_beat_t beat;
    beat.row = 3'(r);
    beat.col = 3'(c);
    beat.value = v[34:0];
    beat.status = st;
    beat.last = last;
    expected_beats.push_back(beat);
  endfunction

  function automatic void predict_matrix_result(cmd_item_t cmd);
    int ar;
    int ac;
    int br;
    int bc;
    longint acc;
    ar = eff_dim(dim_regs[REG_A_ROWS]);
    ac = eff_dim(dim_regs[REG_A_COLS]);
    br = eff_dim(dim_regs[REG_B_ROWS]);
    bc = eff_dim(dim_regs[REG_B_COLS]);
    case (cmd.op)
      OP_WR_A: a_elems[cmd.row][cmd.col] = cmd.value;
      OP_WR_B: b_elems[cmd.row][cmd.col] = cmd.value;
      OP_SUM: begin
        if (ar != br || ac != bc) begin
          push_beat(0, 0, 0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < ar; i++)
            for (int j = 0; j < ac; j++)
              push_beat(i, j, longint'(a_elems[i][j]) + longint'(b_elems[i][j]), 1'b0,
                        i == ar - 1 && j == ac - 1);
        end
      end
      OP_PROD: begin
        if (ac != br) begin
          push_beat(0, 0, 0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < ar; i++)
            for (int j = 0; j < bc; j++) begin
              acc = 0;
              for (int k = 0; k < ac; k++)
                acc += longint'(a_elems[i][k]) * longint'(b_elems[k][j]);
              push_beat(i, j, acc, 1'b0, i == ar - 1 && j == bc - 1);
            end
        end
      end
      OP_TRANS: begin
        for (int i = 0; i < ac; i++)
          for (int j = 0; j < ar; j++)
            push_beat(i, j, longint'(a_elems[j][i]), 1'b0, i == ac - 1 && j == ar - 1);
      end
      default: ;
    endcase
  endfunction

  task automatic check_result_beat();
    elem_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("result beat row %0d col %0d value %0d with none expected",
                                out_ch.out_row, out_ch.out_col, out_ch.out_value));
      return;
    end
    want = expected_beats.pop_front();
    if (out_ch.out_row !== want.row)
      report_mismatch($sformatf("out_row %0d, expected %0d", out_ch.out_row, want.row));
    if (out_ch.out_col !== want.col)
      report_mismatch($sformatf("out_col %0d, expected %0d", out_ch.out_col, want.col));
    if (out_ch.out_value !== want.value)
      report_mismatch($sformatf("out_value %0d, expected %0d at row %0d col %0d",
                                out_ch.out_value, want.value, want.row, want.col));
    if (out_ch.status !== want.status)
      report_mismatch($sformatf("status %0b, expected %0b", out_ch.status, want.status));
    if (out_ch.is_last !== want.last)
      report_mismatch($sformatf("is_last %0b, expected %0b", out_ch.is_last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_WR_A;
      in_ch.row_index <= 3'd0;
      in_ch.col_index <= 3'd0;
      in_ch.elem_value <= 16'sd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_cmd.op = in_ch.op;
        taken_cmd.row = in_ch.row_index;
        taken_cmd.col = in_ch.col_index;
        taken_cmd.value = in_ch.elem_value;
        predict_matrix_result(taken_cmd);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= next_cmd.op;
          in_ch.row_index <= next_cmd.row;
          in_ch.col_index <= next_cmd.col;
          in_ch.elem_value <= next_cmd.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result_beat();
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic add_cmd(logic [2:0] op, logic [2:0] row, logic [2:0] col,
                         logic signed [15:0] value);
    cmd_item_t cmd;
    cmd.op = op;
    cmd.row = row;
    cmd.col = col;
    cmd.value = value;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_random_fields(logic [2:0] op);
    add_cmd(op, 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    dim_regs[idx] = val;
  endtask

  task automatic write_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_random_dims();
    logic [3:0] ar;
    logic [3:0] ac;
    logic [3:0] br;
    logic [3:0] bc;
    ar = 4'($urandom_range(DIM_MAX, 1));
    ac = 4'($urandom_range(DIM_MAX, 1));
    br = 4'($urandom_range(DIM_MAX, 1));
    bc = 4'($urandom_range(DIM_MAX, 1));
    case ($urandom_range(3, 0))
      0: begin
        ac = ar;
        br = ar;
        bc = ar;
      end
      1: begin
        br = ar;
        bc = ac;
      end
      2: br = ac;
      default: begin
        ar = 4'($urandom);
        ac = 4'($urandom);
        br = 4'($urandom);
        bc = 4'($urandom);
      end
    endcase
    write_dims(ar, ac, br, bc);
  endtask

  task automatic queue_random_items(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) add_random_fields(($urandom_range(1, 0) != 0) ? OP_WR_B : OP_WR_A);
      else if (pick < 72) add_random_fields(OP_SUM);
      else if (pick < 86) add_random_fields(OP_PROD);
      else if (pick < 96) add_random_fields(OP_TRANS);
      else add_random_fields(OP_RSVD_FIRST + 3'($urandom_range(2, 0)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_A_ROWS;
    cfg_wdata = 4'd0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (dim_regs[i]) dim_regs[i] = 4'd8;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p < 5) begin
        send_idle_pct = 17;
        recv_stall_pct = 48;
      end else if (p < 10) begin
        send_idle_pct = 48;
        recv_stall_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: begin
          write_dims(4'd8, 4'd8, 4'd8, 4'd8);
          @(negedge clk);
          // Row 0 of A and column 0 of B hold the most negative value so that
          // the product reaches its largest magnitude.
          for (int r = 0; r < DIM_MAX; r++)
            for (int c = 0; c < DIM_MAX; c++) begin
              add_cmd(OP_WR_A, 3'(r), 3'(c), (r == 0) ? 16'sh8000 : 16'($urandom));
              add_cmd(OP_WR_B, 3'(r), 3'(c), (c == 0) ? 16'sh8000 : 16'($urandom));
            end
          add_cmd(OP_WR_A, 3'd7, 3'd7, 16'sh7fff);
          add_cmd(OP_WR_B, 3'd7, 3'd7, 16'sh7fff);
          add_cmd(OP_WR_A, 3'd3, 3'd4, 16'sh0000);
          add_cmd(OP_WR_B, 3'd0, 3'd7, 16'shffff);
          add_random_fields(OP_SUM);
          add_random_fields(OP_PROD);
          add_random_fields(OP_TRANS);
          add_random_fields(OP_RSVD_FIRST);
          add_random_fields(OP_RSVD_FIRST + 3'd1);
          add_random_fields(OP_RSVD_FIRST + 3'd2);
        end
        1: begin
          write_dims(4'd0, 4'd15, 4'd15, 4'd0);
          @(negedge clk);
          add_random_fields(OP_SUM);
          add_random_fields(OP_PROD);
          add_random_fields(OP_TRANS);
        end
        2: begin
          write_dims(4'd8, 4'd1, 4'd2, 4'd8);
          @(negedge clk);
          add_random_fields(OP_SUM);
          add_random_fields(OP_PROD);
          add_random_fields(OP_TRANS);
        end
        default: begin
          pick_random_dims();
          @(negedge clk);
          queue_random_items(RANDOM_ITEMS);
        end
      endcase
      wait_idle();
    end

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== matrix_add_multiply_transpose_top.f =====
src/mam_pkg.sv
src/mam_if.sv
src/mam_ram.sv
src/mam_seq.sv
src/mam_alu.sv
src/matrix_add_multiply_transpose_top.sv
tb/matrix_add_multiply_transpose_top_test.sv
